>>> sv/gcrb_pkg.sv
// Shared constants, stage state types and the arctangent table for the range and bearing pipeline.
package gcrb_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int SQRT_STEPS    = 31;
    localparam int SQRT_TOP      = 2 * (SQRT_STEPS - 1);
    localparam int STEP_W        = 5;

    localparam int LAT_W    = 24;
    localparam int LON_W    = 25;
    localparam int DIST_W   = 19;
    localparam int BRG_W    = 15;
    localparam int RADIUS_W = 13;

    localparam int ANG_W  = 32;
    localparam int ROT_W  = 34;
    localparam int VEC_W  = 35;
    localparam int ROOT_W = 62;
    localparam int TRIG_W = 32;

    localparam logic [RADIUS_W-1:0]    RADIUS_RESET = 13'd6371;
    localparam logic signed [ROT_W-1:0] INV_GAIN    = 34'sd652032874;
    localparam logic [ANG_W-1:0]       HALF_TURN    = 32'h8000_0000;

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic [ANG_W-1:0]        z;
        logic                    flip;
    } rot_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [ANG_W-1:0]        z;
        logic                    zero;
    } vec_t;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    // Arctangent of 2^-i in binary angle units (2^32 per turn).
    function automatic logic [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            5'd28:   v = 32'd3;
            5'd29:   v = 32'd1;
            5'd30:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/gcrb_rot_cell.sv
// One rotation-mode CORDIC cell: a single micro-rotation toward a zero residual angle.
module gcrb_rot_cell (
    input  logic                         clk,
    input  logic                         en,
    input  logic [gcrb_pkg::STEP_W-1:0]  step,
    input  gcrb_pkg::rot_t               d,
    output gcrb_pkg::rot_t               q
);
    import gcrb_pkg::*;

    rot_t                    state_reg;
    rot_t                    state_next;
    logic signed [ROT_W-1:0] x_in;
    logic signed [ROT_W-1:0] y_in;
    logic signed [ROT_W-1:0] dx;
    logic signed [ROT_W-1:0] dy;
    logic [ANG_W-1:0]        at;

    always_comb
    begin
        x_in = d.x;
        y_in = d.y;
        dx   = y_in >>> step;
        dy   = x_in >>> step;
        at   = atan_entry(step);
        state_next.flip = d.flip;
        if (d.z[ANG_W-1])
        begin
            state_next.x = x_in + dx;
            state_next.y = y_in - dy;
            state_next.z = d.z + at;
        end
        else
        begin
            state_next.x = x_in - dx;
            state_next.y = y_in + dy;
            state_next.z = d.z - at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign q = state_reg;

endmodule

>>> sv/gcrb_vec_cell.sv
// One vectoring-mode CORDIC cell: drives y toward zero and accumulates the angle.
module gcrb_vec_cell (
    input  logic                         clk,
    input  logic                         en,
    input  logic [gcrb_pkg::STEP_W-1:0]  step,
    input  gcrb_pkg::vec_t               d,
    output gcrb_pkg::vec_t               q
);
    import gcrb_pkg::*;

    vec_t                    state_reg;
    vec_t                    state_next;
    logic signed [VEC_W-1:0] x_in;
    logic signed [VEC_W-1:0] y_in;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    logic [ANG_W-1:0]        at;

    always_comb
    begin
        x_in = d.x;
        y_in = d.y;
        dx   = y_in >>> step;
        dy   = x_in >>> step;
        at   = atan_entry(step);
        state_next.zero = d.zero;
        if (y_in > 0)
        begin
            state_next.x = x_in + dx;
            state_next.y = y_in - dy;
            state_next.z = d.z + at;
        end
        else
        begin
            state_next.x = x_in - dx;
            state_next.y = y_in + dy;
            state_next.z = d.z - at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign q = state_reg;

endmodule

>>> sv/gcrb_sqrt_cell.sv
// One digit of a restoring integer square root: resolves one result bit per cell.
module gcrb_sqrt_cell (
    input  logic                         clk,
    input  logic                         en,
    input  logic [gcrb_pkg::STEP_W-1:0]  step,
    input  gcrb_pkg::sqrt_t              d,
    output gcrb_pkg::sqrt_t              q
);
    import gcrb_pkg::*;

    sqrt_t             state_reg;
    sqrt_t             state_next;
    logic [ROOT_W-1:0] one_bit;
    logic [ROOT_W-1:0] trial;

    always_comb
    begin
        one_bit = ROOT_W'(1) << (SQRT_TOP - 2 * int'(step));
        trial   = d.root + one_bit;
        if (d.rem >= trial)
        begin
            state_next.rem  = d.rem - trial;
            state_next.root = (d.root >> 1) + one_bit;
        end
        else
        begin
            state_next.rem  = d.rem;
            state_next.root = d.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign q = state_reg;

endmodule

>>> sv/great_circle_range_bearing.sv
// Top level: fully pipelined haversine distance and initial bearing between two positions.
//
// This block takes one request per clock while the pipeline advances, a pair of positions in
// degrees times 65536, and returns the great-circle distance in 1/16 km on a sphere of the
// configured radius together with the initial bearing in 1/64 degree, clockwise from north.
// Every request travels the same pipeline of 2*CORDIC_STAGES+39 stages (87 with 24 CORDIC
// stages), and a new request can be taken in every cycle in which the pipeline advances.
// The depth is set by the chains of cells: the rotation chains for the sines and cosines,
// a 31-cell square-root chain and a vectoring chain for the central angle. The
// bearing arctangent runs beside the square roots and is delayed to meet the distance. The
// whole pipeline advances together; it holds only while a finished result waits with
// res_stall high, and pos_stall is raised exactly then. The radius register resets to
// 6371 km and must be written only while no request is in flight.
module great_circle_range_bearing (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [gcrb_pkg::RADIUS_W-1:0]         cfg_wdata,
    input  logic                                  pos_valid,
    output logic                                  pos_stall,
    input  logic signed [gcrb_pkg::LAT_W-1:0]     from_latitude,
    input  logic signed [gcrb_pkg::LON_W-1:0]     from_longitude,
    input  logic signed [gcrb_pkg::LAT_W-1:0]     to_latitude,
    input  logic signed [gcrb_pkg::LON_W-1:0]     to_longitude,
    output logic                                  res_valid,
    input  logic                                  res_stall,
    output logic [gcrb_pkg::DIST_W-1:0]           distance,
    output logic [gcrb_pkg::BRG_W-1:0]            bearing
);
    import gcrb_pkg::*;

    // Stages: three for angle conversion, the rotation chain, sine/cosine fixup, two
    // product stages, the root chain, the vectoring chain, scaling and the output.
    localparam int PIPE_DEPTH = 2 * CORDIC_STAGES + SQRT_STEPS + 8;

    localparam logic signed [26:0]       TURN_OFFSET = 27'sd23592960;
    localparam logic [26:0]              RECIP_45    = 27'd95443718;
    localparam logic [25:0]              CONV_DIV    = 26'd45;
    localparam logic [18:0]              CONV_BIAS   = 19'd22;
    localparam logic [31:0]              PI_Q30      = 32'd3373259426;
    localparam logic [15:0]              BRG_SCALE   = 16'd23040;
    localparam logic [BRG_W-1:0]         BRG_LIMIT   = 15'd23040;
    localparam logic [19:0]              DIST_MAX    = 20'd524287;
    localparam logic [30:0]              Q_ONE31     = 31'h4000_0000;
    localparam logic signed [ROT_W-1:0]  Q_ONE_ROT   = 34'sd1073741824;

    function automatic logic signed [TRIG_W-1:0] clamp_trig(input logic signed [ROT_W-1:0] v);
        logic signed [TRIG_W-1:0] r;
        if (v > Q_ONE_ROT)
        begin
            r = 32'sh4000_0000;
        end
        else if (v < -Q_ONE_ROT)
        begin
            r = -32'sh4000_0000;
        end
        else
        begin
            r = v[TRIG_W-1:0];
        end
        return r;
    endfunction

    // Round a Q60 product back to Q30, ties toward plus infinity.
    function automatic logic signed [TRIG_W-1:0] rnd30(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd536870912;
        return t[61:30];
    endfunction

    function automatic logic signed [TRIG_W-1:0] hav(input logic signed [TRIG_W-1:0] c);
        logic signed [32:0] t;
        t = 33'sd1073741825 - 33'(c);
        return t[32:1];
    endfunction

    // Fold the left half plane onto the right one before vectoring.
    function automatic vec_t vec_init(input logic signed [VEC_W-1:0] y,
                                      input logic signed [VEC_W-1:0] x);
        vec_t v;
        v.zero = (x == '0) && (y == '0);
        if (x < 0)
        begin
            v.x = -x;
            v.y = -y;
            v.z = HALF_TURN;
        end
        else
        begin
            v.x = x;
            v.y = y;
            v.z = '0;
        end
        return v;
    endfunction

    logic                  adv;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [RADIUS_W-1:0]   radius_reg;

    // The pipeline moves as one; it only holds while the output register is full and
    // the consumer stalls.
    assign adv       = !(vld_reg[PIPE_DEPTH-1] && res_stall);
    assign pos_stall = !adv;
    assign res_valid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], pos_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            radius_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Degrees*65536 to binary angle: floor((u*8192+22)/45) with u offset to
    // be positive, split as u = 45q + r so both divides stay narrow.
    // Order of the four angles: from lat, from lon, to lat, to lon.
    // ------------------------------------------------------------------
    logic signed [LON_W-1:0] coord    [4];
    logic [25:0]             u_c      [4];
    logic [52:0]             qprod_c  [4];
    logic [25:0]             rem_c    [4];
    logic [18:0]             w_c      [4];
    logic [45:0]             q2prod_c [4];
    logic [25:0]             u_reg    [4];
    logic [20:0]             cq_reg   [4];
    logic [5:0]              r_reg    [4];
    logic [20:0]             cq2_reg  [4];
    logic [ANG_W-1:0]        ang_reg  [4];

    assign coord[0] = LON_W'(from_latitude);
    assign coord[1] = from_longitude;
    assign coord[2] = LON_W'(to_latitude);
    assign coord[3] = to_longitude;

    always_comb
    begin
        logic signed [26:0] sum;
        for (int i = 0; i < 4; i++)
        begin
            sum         = 27'(coord[i]) + TURN_OFFSET;
            u_c[i]      = sum[25:0];
            qprod_c[i]  = 53'(u_c[i]) * 53'(RECIP_45);
            rem_c[i]    = u_reg[i] - (26'(cq_reg[i]) * CONV_DIV);
            w_c[i]      = {r_reg[i], 13'b0} + CONV_BIAS;
            q2prod_c[i] = 46'(w_c[i]) * 46'(RECIP_45);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                u_reg[i]   <= u_c[i];
                cq_reg[i]  <= qprod_c[i][52:32];
                r_reg[i]   <= rem_c[i][5:0];
                cq2_reg[i] <= cq_reg[i];
                ang_reg[i] <= {cq2_reg[i][18:0], q2prod_c[i][44:32]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Rotation chains. Chain order: latitude A, latitude B, latitude
    // difference, longitude difference. Quadrants two and three are
    // turned by half a turn and the result negated afterwards.
    // ------------------------------------------------------------------
    logic [ANG_W-1:0]         rot_ang  [4];
    rot_t                     rot_d    [4][CORDIC_STAGES];
    rot_t                     rot_q    [4][CORDIC_STAGES];
    logic signed [TRIG_W-1:0] cos_reg  [4];
    logic signed [TRIG_W-1:0] sin_reg  [4];

    assign rot_ang[0] = ang_reg[0];
    assign rot_ang[1] = ang_reg[2];
    assign rot_ang[2] = ang_reg[2] - ang_reg[0];
    assign rot_ang[3] = ang_reg[3] - ang_reg[1];

    always_comb
    begin
        logic flip;
        for (int c = 0; c < 4; c++)
        begin
            flip              = rot_ang[c][ANG_W-1] ^ rot_ang[c][ANG_W-2];
            rot_d[c][0].flip  = flip;
            rot_d[c][0].x     = INV_GAIN;
            rot_d[c][0].y     = '0;
            rot_d[c][0].z     = flip ? (rot_ang[c] ^ HALF_TURN) : rot_ang[c];
            for (int k = 1; k < CORDIC_STAGES; k++)
            begin
                rot_d[c][k] = rot_q[c][k-1];
            end
        end
    end

    for (genvar c = 0; c < 4; c++)
    begin : g_rot
        for (genvar k = 0; k < CORDIC_STAGES; k++)
        begin : g_cell
            gcrb_rot_cell u_cell (
                .clk  (clk),
                .en   (adv),
                .step (STEP_W'(k)),
                .d    (rot_d[c][k]),
                .q    (rot_q[c][k])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (rot_q[c][CORDIC_STAGES-1].flip)
                begin
                    cos_reg[c] <= clamp_trig(-rot_q[c][CORDIC_STAGES-1].x);
                    sin_reg[c] <= clamp_trig(-rot_q[c][CORDIC_STAGES-1].y);
                end
                else
                begin
                    cos_reg[c] <= clamp_trig(rot_q[c][CORDIC_STAGES-1].x);
                    sin_reg[c] <= clamp_trig(rot_q[c][CORDIC_STAGES-1].y);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Products. The first stage forms every product of two trig values and
    // the two haversines, the second the products with the first stage's results.
    // ------------------------------------------------------------------
    logic signed [TRIG_W-1:0] hc_reg;
    logic signed [TRIG_W-1:0] yv_reg;
    logic signed [TRIG_W-1:0] t1_reg;
    logic signed [TRIG_W-1:0] t2_reg;
    logic signed [TRIG_W-1:0] hlat_reg;
    logic signed [TRIG_W-1:0] hlon_reg;
    logic signed [TRIG_W-1:0] clon_reg;
    logic signed [32:0]       a_sum;
    logic [30:0]              a_reg;
    logic signed [32:0]       xv_reg;
    logic signed [TRIG_W-1:0] yv2_reg;

    assign a_sum = 33'(hlat_reg) + 33'(rnd30(64'(hc_reg) * 64'(hlon_reg)));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hc_reg   <= rnd30(64'(cos_reg[0]) * 64'(cos_reg[1]));
            yv_reg   <= rnd30(64'(sin_reg[3]) * 64'(cos_reg[1]));
            t1_reg   <= rnd30(64'(cos_reg[0]) * 64'(sin_reg[1]));
            t2_reg   <= rnd30(64'(sin_reg[0]) * 64'(cos_reg[1]));
            hlat_reg <= hav(cos_reg[2]);
            hlon_reg <= hav(cos_reg[3]);
            clon_reg <= cos_reg[3];

            if (a_sum < 0)
            begin
                a_reg <= '0;
            end
            else if (a_sum > 33'(Q_ONE31))
            begin
                a_reg <= Q_ONE31;
            end
            else
            begin
                a_reg <= a_sum[30:0];
            end
            xv_reg  <= 33'(t1_reg) - 33'(rnd30(64'(t2_reg) * 64'(clon_reg)));
            yv2_reg <= yv_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square roots of a and 1-a, both scaled to Q60.
    // ------------------------------------------------------------------
    sqrt_t sq_d [2][SQRT_STEPS];
    sqrt_t sq_q [2][SQRT_STEPS];

    always_comb
    begin
        sq_d[0][0].rem  = ROOT_W'({a_reg, 30'b0});
        sq_d[0][0].root = '0;
        sq_d[1][0].rem  = ROOT_W'({Q_ONE31 - a_reg, 30'b0});
        sq_d[1][0].root = '0;
        for (int s = 0; s < 2; s++)
        begin
            for (int k = 1; k < SQRT_STEPS; k++)
            begin
                sq_d[s][k] = sq_q[s][k-1];
            end
        end
    end

    for (genvar s = 0; s < 2; s++)
    begin : g_sqrt
        for (genvar k = 0; k < SQRT_STEPS; k++)
        begin : g_cell
            gcrb_sqrt_cell u_cell (
                .clk  (clk),
                .en   (adv),
                .step (STEP_W'(k)),
                .d    (sq_d[s][k]),
                .q    (sq_q[s][k])
            );
        end
    end

    // ------------------------------------------------------------------
    // Vectoring chains: chain 0 gives the central half-angle from the two
    // roots, chain 1 the bearing, which then waits out the root chain.
    // ------------------------------------------------------------------
    vec_t             vec_d    [2][CORDIC_STAGES];
    vec_t             vec_q    [2][CORDIC_STAGES];
    logic [ANG_W-1:0] bdly_reg [SQRT_STEPS];

    always_comb
    begin
        vec_d[0][0] = vec_init(VEC_W'(sq_q[0][SQRT_STEPS-1].root),
                               VEC_W'(sq_q[1][SQRT_STEPS-1].root));
        vec_d[1][0] = vec_init(VEC_W'(yv2_reg), VEC_W'(xv_reg));
        for (int v = 0; v < 2; v++)
        begin
            for (int k = 1; k < CORDIC_STAGES; k++)
            begin
                vec_d[v][k] = vec_q[v][k-1];
            end
        end
    end

    for (genvar v = 0; v < 2; v++)
    begin : g_vec
        for (genvar k = 0; k < CORDIC_STAGES; k++)
        begin : g_cell
            gcrb_vec_cell u_cell (
                .clk  (clk),
                .en   (adv),
                .step (STEP_W'(k)),
                .d    (vec_d[v][k]),
                .q    (vec_q[v][k])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bdly_reg[0] <= vec_q[1][CORDIC_STAGES-1].zero ? '0 : vec_q[1][CORDIC_STAGES-1].z;
            for (int k = 1; k < SQRT_STEPS; k++)
            begin
                bdly_reg[k] <= bdly_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Scaling: half-angle to arc length, then radius; bearing to 1/64 degree.
    // A half-angle that came out negative counts as zero.
    // ------------------------------------------------------------------
    logic [ANG_W-1:0]  h_sel;
    logic [30:0]       h_clamp;
    logic [62:0]       hprod;
    logic [47:0]       bprod;
    logic [15:0]       bscaled;
    logic [49:0]       dprod;
    logic [36:0]       dist1_reg;
    logic [BRG_W-1:0]  brg_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [BRG_W-1:0]  bear_reg;

    always_comb
    begin
        h_sel = vec_q[0][CORDIC_STAGES-1].zero ? '0 : vec_q[0][CORDIC_STAGES-1].z;
        if (h_sel[ANG_W-1])
        begin
            h_clamp = '0;
        end
        else if (h_sel > 32'(Q_ONE31))
        begin
            h_clamp = Q_ONE31;
        end
        else
        begin
            h_clamp = h_sel[30:0];
        end
        hprod   = 63'(h_clamp) * 63'(PI_Q30) + 63'h200_0000;
        bprod   = 48'(bdly_reg[SQRT_STEPS-1]) * 48'(BRG_SCALE) + 48'h8000_0000;
        bscaled = bprod[47:32];
        dprod   = 50'(radius_reg) * 50'(dist1_reg) + 50'h2000_0000;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist1_reg <= hprod[62:26];
            brg_reg   <= (bscaled >= BRG_SCALE) ? '0 : bscaled[BRG_W-1:0];
            dist_reg  <= (dprod[49:30] > DIST_MAX) ? DIST_MAX[DIST_W-1:0] : dprod[48:30];
            bear_reg  <= brg_reg;
        end
    end

    assign distance = dist_reg;
    assign bearing  = bear_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (bearing < BRG_LIMIT))
        else $error("bearing out of range");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pos_stall |=> (vld_reg == $past(vld_reg)))
        else $error("pipeline moved while stalled");

    a_request_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_valid && !pos_stall) |=> vld_reg[0])
        else $error("accepted request lost at entry");

    a_radius_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (radius_reg == $past(cfg_wdata)))
        else $error("radius write not taken");

endmodule
